// File: hdl/gha_pkg.sv
// Shared constants and types for the generational handle allocator.
`default_nettype none
package gha_pkg;

   localparam int SLOTS_PER_BLOCK_DEF = 64;
   localparam int BLOCK_LIMIT_DEF     = 16;

   localparam int HANDLE_W = 32;
   localparam int INDEX_W  = 24;
   localparam int GEN_W    = 8;
   localparam int STATUS_W = 2;

   localparam logic [HANDLE_W-1:0] LINK_MARK  = 32'hFF00_0000;
   localparam logic [HANDLE_W-1:0] INDEX_MASK = 32'h00FF_FFFF;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [GEN_W-1:0]    gen_type;
   typedef logic [INDEX_W-1:0]  index_type;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_EXHAUSTED = 2'd1;
   localparam status_type STATUS_RETIRED   = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_NEVER_REISSUE = 1'b0;

endpackage
`default_nettype wire

// File: hdl/gha_req_bus.sv
// Request channel: command and handle to release.
`default_nettype none
interface gha_req_bus;
   import gha_pkg::*;

   logic       valid;
   logic       ready;
   logic       command;
   handle_type handle_in;

   modport source (output valid, output command, output handle_in, input ready);
   modport sink (input valid, input command, input handle_in, output ready);
endinterface
`default_nettype wire

// File: hdl/gha_rsp_bus.sv
// Response channel: allocated handle and status.
`default_nettype none
interface gha_rsp_bus;
   import gha_pkg::*;

   logic       valid;
   logic       ready;
   handle_type handle_out;
   status_type status;

   modport source (output valid, output handle_out, output status, input ready);
   modport sink (input valid, input handle_out, input status, output ready);
endinterface
`default_nettype wire

// File: hdl/gha_csr.sv
// APB-style configuration register holding the never-reissue flag.
`default_nettype none
module gha_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [gha_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [gha_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [gha_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready,
   output logic                                   never_reissue
);
   import gha_pkg::*;

   logic never_reissue_ff;
   logic never_reissue_in;
   logic reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[CSR_ADDR_W-1] == REG_NEVER_REISSUE);

   always_comb begin
      never_reissue_in = never_reissue_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         never_reissue_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         never_reissue_ff <= 1'b0;
      end else begin
         never_reissue_ff <= never_reissue_in;
      end
   end

   assign prdata        = reg_hit ? {{(CSR_DATA_W-1){1'b0}}, never_reissue_ff} : '0;
   assign never_reissue = never_reissue_ff;
endmodule
`default_nettype wire

// File: hdl/gha_ctrl.sv
// Sequencer, slot memories and list heads of the handle allocator.
`default_nettype none
module gha_ctrl #(
   parameter int SLOTS_PER_BLOCK = gha_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int BLOCK_LIMIT     = gha_pkg::BLOCK_LIMIT_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   never_reissue,
   gha_req_bus.sink    req_bus,
   gha_rsp_bus.source  rsp_bus
);
   import gha_pkg::*;

   localparam int SLOT_TOTAL = SLOTS_PER_BLOCK * BLOCK_LIMIT;
   localparam int AW = $clog2(SLOT_TOTAL);
   localparam int LW = $clog2(SLOT_TOTAL + 1);
   localparam int CW = $clog2(SLOTS_PER_BLOCK);
   localparam int XW = INDEX_W + 1;

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ALLOC  = 3'd2;
   localparam logic [2:0] ST_CHAIN  = 3'd3;
   localparam logic [2:0] ST_POP    = 3'd4;
   localparam logic [2:0] ST_REL    = 3'd5;
   localparam logic [2:0] ST_RELCHK = 3'd6;

   logic [HANDLE_W-1:0] link_mem [SLOT_TOTAL];
   gen_type             gen_mem  [SLOT_TOTAL];

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] base_ff, base_in;
   logic [LW-1:0] live_ff, live_in;
   handle_type    free_head_ff, free_head_in;
   handle_type    deferred_ff, deferred_in;
   handle_type    handle_ff, handle_in;
   handle_type    link_rd_ff;
   gen_type       gen_rd_ff;
   handle_type    out_handle_ff, out_handle_in;
   status_type    out_status_ff, out_status_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          link_we;
   logic          gen_we;
   logic [AW-1:0] wr_addr;
   handle_type    link_wd;
   gen_type       gen_wd;

   index_type     free_idx;
   index_type     rel_idx;
   logic          free_oob;
   logic          rel_oob;
   logic          rel_block0;
   logic          can_chain;
   logic [AW-1:0] sweep_addr;
   logic          sweep_last;
   logic [XW-1:0] next_link;
   gen_type       gen_inc;
   logic          gen_wrap;
   logic          accept;
   logic          done;

   assign accept     = req_bus.valid && req_bus.ready;
   assign free_idx   = free_head_ff[INDEX_W-1:0];
   assign rel_idx    = handle_ff[INDEX_W-1:0];
   assign free_oob   = {1'b0, free_idx} >= XW'(live_ff);
   assign rel_oob    = {1'b0, rel_idx} >= XW'(live_ff);
   assign rel_block0 = {1'b0, rel_idx} < XW'(SLOTS_PER_BLOCK);
   assign can_chain  = (XW'(live_ff) < XW'(SLOT_TOTAL)) && (XW'(live_ff) < XW'(INDEX_MASK));
   assign sweep_addr = base_ff + AW'(cnt_ff);
   assign sweep_last = (cnt_ff == CW'(SLOTS_PER_BLOCK - 1));
   assign next_link  = {1'b0, INDEX_W'(sweep_addr)} + XW'(1);
   assign gen_inc    = gen_rd_ff + GEN_W'(1);
   assign gen_wrap   = (gen_inc == '0);
   assign rd_addr    = (state_ff == ST_ALLOC) ? free_idx[AW-1:0] : rel_idx[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      live_in       = live_ff;
      free_head_in  = free_head_ff;
      deferred_in   = deferred_ff;
      handle_in     = handle_ff;
      out_handle_in = out_handle_ff;
      out_status_in = out_status_ff;
      done          = 1'b0;
      rd_en         = 1'b0;
      link_we       = 1'b0;
      gen_we        = 1'b0;
      wr_addr       = rel_idx[AW-1:0];
      link_wd       = deferred_ff;
      gen_wd        = gen_inc;

      if (state_ff inside {ST_INIT, ST_CHAIN}) begin
         wr_addr = sweep_addr;
         link_we = 1'b1;
         gen_we  = 1'b1;
         link_wd = sweep_last ? '0 : (LINK_MARK | {8'h00, next_link[INDEX_W-1:0]});
         gen_wd  = ((state_ff == ST_INIT) && (cnt_ff == '0)) ? GEN_W'(1) : '0;
      end

      case (state_ff)
         ST_INIT, ST_CHAIN: begin
            cnt_in = cnt_ff + CW'(1);
            if (sweep_last) begin
               state_in = ST_IDLE;
               if (state_ff == ST_INIT) begin
                  free_head_in = LINK_MARK;
               end else begin
                  free_head_in = HANDLE_W'(base_ff);
                  live_in      = live_ff + LW'(SLOTS_PER_BLOCK);
                  state_in     = ST_ALLOC;
               end
            end
         end
         ST_IDLE: begin
            if (accept) begin
               handle_in = req_bus.handle_in;
               state_in  = (req_bus.command == CMD_ALLOC) ? ST_ALLOC : ST_REL;
            end
         end
         ST_ALLOC: begin
            if (free_head_ff == '0) begin
               if (deferred_ff != '0) begin
                  free_head_in = deferred_ff;
                  deferred_in  = '0;
               end else if (can_chain) begin
                  base_in  = AW'(live_ff);
                  cnt_in   = '0;
                  state_in = ST_CHAIN;
               end else begin
                  done          = 1'b1;
                  out_handle_in = '0;
                  out_status_in = STATUS_EXHAUSTED;
               end
            end else if (free_oob) begin
               free_head_in = '0;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            free_head_in  = link_rd_ff;
            done          = 1'b1;
            out_handle_in = {gen_rd_ff, free_idx};
            out_status_in = STATUS_OK;
         end
         ST_REL: begin
            if (rel_oob) begin
               done          = 1'b1;
               out_handle_in = '0;
               out_status_in = STATUS_OK;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_RELCHK;
            end
         end
         ST_RELCHK: begin
            done          = 1'b1;
            out_handle_in = '0;
            out_status_in = STATUS_OK;
            if (handle_ff[HANDLE_W-1:INDEX_W] == gen_rd_ff) begin
               gen_we = 1'b1;
               if (gen_wrap && never_reissue) begin
                  gen_wd        = '0;
                  out_status_in = STATUS_RETIRED;
               end else begin
                  gen_wd      = (gen_wrap && rel_block0) ? GEN_W'(1) : gen_inc;
                  link_we     = 1'b1;
                  link_wd     = deferred_ff;
                  deferred_in = handle_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         state_in = ST_IDLE;
      end
      rsp_valid_in = done ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         base_ff      <= '0;
         live_ff      <= LW'(SLOTS_PER_BLOCK);
         free_head_ff <= LINK_MARK;
         deferred_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         live_ff      <= live_in;
         free_head_ff <= free_head_in;
         deferred_ff  <= deferred_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff     <= handle_in;
      out_handle_ff <= out_handle_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[wr_addr] <= link_wd;
      end
      if (gen_we) begin
         gen_mem[wr_addr] <= gen_wd;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[rd_addr];
         gen_rd_ff  <= gen_mem[rd_addr];
      end
   end

   assign req_bus.ready      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.handle_out = out_handle_ff;
   assign rsp_bus.status     = out_status_ff;
endmodule
`default_nettype wire

// File: hdl/generational_handle_allocator.sv
// Flow: an accepted item passes through ST_ALLOC and ST_POP for a plain pop, or ST_REL and ST_RELCHK for a release.
// Promoting the deferred list or dropping a bad free-list entry adds another pass through ST_ALLOC.
// Chaining in a block first sweeps its slots through the memory write port in ST_CHAIN.
// One item at a time: the next is accepted only back in ST_IDLE with room in the result register.
// Reset: synchronous; block 0 is then initialized in ST_INIT, during which the block is not ready.
`default_nettype none
module generational_handle_allocator #(
   parameter int SLOTS_PER_BLOCK = gha_pkg::SLOTS_PER_BLOCK_DEF,
   parameter int BLOCK_LIMIT     = gha_pkg::BLOCK_LIMIT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   gha_req_bus.sink                               req_bus,
   gha_rsp_bus.source                             rsp_bus,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [gha_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [gha_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [gha_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import gha_pkg::*;

   logic never_reissue;

   gha_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .never_reissue (never_reissue)
   );

   gha_ctrl #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .BLOCK_LIMIT     (BLOCK_LIMIT)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .never_reissue (never_reissue),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("ready after an accepted item");

   a_init_after_reset: assert property (@(posedge clock)
      reset |=> !req_bus.ready)
      else $error("ready during block 0 initialization");

   a_error_no_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != STATUS_OK) |-> (rsp_bus.handle_out == '0))
      else $error("handle given with an error status");

   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("ready while the result register is full");
`endif
endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for the generational handle allocator: directed, random and wrap-around traffic.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gha_pkg::*;

   localparam int SLOTS  = SLOTS_PER_BLOCK_DEF;
   localparam int BLOCKS = BLOCK_LIMIT_DEF;
   localparam int SLOT_TOTAL = SLOTS * BLOCKS;
   localparam logic [CSR_ADDR_W-1:0] POLICY_ADDR = CSR_ADDR_W'(4 * int'(REG_NEVER_REISSUE));

   typedef struct packed {
      handle_type handle;
      status_type status;
   } slot_reply_t;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   gha_req_bus req_if ();
   gha_rsp_bus rsp_if ();

   generational_handle_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // allocator state as the testbench expects it
   handle_type slot_link [SLOT_TOTAL];
   gen_type    slot_gen [SLOT_TOTAL];
   handle_type free_head;
   handle_type deferred_head;
   int unsigned blocks_in_use;
   logic retire_wrapped;

   slot_reply_t awaited_replies [$];
   handle_type issued_handles [$];
   handle_type released_log [$];
   int mismatches = 0;
   int src_idle_pct = 0;
   int rsp_stall_pct = 0;

   function automatic slot_reply_t predict_handle_op(input logic cmd, input handle_type h);
      slot_reply_t r;
      int unsigned idx;
      int unsigned live;
      int unsigned base;
      r.handle = '0;
      r.status = STATUS_OK;
      live = blocks_in_use * SLOTS;
      if (cmd == CMD_ALLOC) begin
         forever begin
            if (free_head == '0) begin
               if (deferred_head != '0) begin
                  free_head = deferred_head;
                  deferred_head = '0;
               end else if (blocks_in_use >= BLOCKS || live >= INDEX_MASK) begin
                  r.status = STATUS_EXHAUSTED;
                  return r;
               end else begin
                  base = live;
                  for (int i = 0; i < SLOTS; i++) begin
                     slot_link[base + i] = LINK_MARK | ((base + i + 1) & INDEX_MASK);
                     slot_gen[base + i] = '0;
                  end
                  slot_link[base + SLOTS - 1] = free_head;
                  free_head = base;
                  blocks_in_use++;
                  live = blocks_in_use * SLOTS;
               end
            end else begin
               idx = free_head & INDEX_MASK;
               if (idx >= live) begin
                  free_head = '0;
               end else begin
                  free_head = slot_link[idx];
                  r.handle = {slot_gen[idx], index_type'(idx)};
                  return r;
               end
            end
         end
      end
      idx = h & INDEX_MASK;
      if (idx >= live) return r;
      if (h[31:24] != slot_gen[idx]) return r;
      slot_gen[idx] = slot_gen[idx] + 1'b1;
      if (slot_gen[idx] == '0) begin
         if (retire_wrapped) begin
            r.status = STATUS_RETIRED;
            return r;
         end
         if (idx < SLOTS) slot_gen[idx] = 1;
      end
      slot_link[idx] = deferred_head;
      deferred_head = h;
      return r;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      slot_reply_t want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (awaited_replies.size() == 0) begin
            note_mismatch($sformatf("unexpected item handle_out %h status %0d",
                                    rsp_if.handle_out, rsp_if.status));
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_if.handle_out !== want.handle)
               note_mismatch($sformatf("handle_out expected %h got %h",
                                       want.handle, rsp_if.handle_out));
            if (rsp_if.status !== want.status)
               note_mismatch($sformatf("status expected %0d got %0d (handle %h)",
                                       want.status, rsp_if.status, want.handle));
         end
      end
   end

   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

   task automatic send_command(input logic cmd, input handle_type h, output slot_reply_t r);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.handle_in <= h;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      r = predict_handle_op(cmd, h);
      awaited_replies.push_back(r);
      if (cmd == CMD_ALLOC && r.status == STATUS_OK) issued_handles.push_back(r.handle);
      if (cmd == CMD_RELEASE) begin
         released_log.push_back(h);
         if (released_log.size() > 64) void'(released_log.pop_front());
      end
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write the policy bit, then read it back
   task automatic set_reissue_policy(input logic retire);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= POLICY_ADDR;
      csr_pwdata <= CSR_DATA_W'(retire);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      retire_wrapped = retire;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== CSR_DATA_W'(retire))
         note_mismatch($sformatf("never_reissue read expected %0d got %h", retire, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_corner_cases();
      slot_reply_t r;
      src_idle_pct = 0;
      rsp_stall_pct = 0;
      send_command(CMD_ALLOC, 32'h0000_0000, r);
      send_command(CMD_ALLOC, 32'hFFFF_FFFF, r);
      send_command(CMD_RELEASE, 32'h0100_0000, r);
      send_command(CMD_RELEASE, 32'h0100_0000, r);
      send_command(CMD_RELEASE, 32'h0000_0040, r);
      send_command(CMD_RELEASE, 32'hFFFF_FFFF, r);
      send_command(CMD_RELEASE, 32'h00FF_FFFF, r);
      send_command(CMD_RELEASE, 32'hFF00_0001, r);
      send_command(CMD_RELEASE, 32'h0000_0030, r);
      send_command(CMD_RELEASE, 32'h0000_003F, r);
      send_command(CMD_RELEASE, 32'h0000_0001, r);
      send_command(CMD_RELEASE, 32'h0000_0000, r);
      send_command(CMD_ALLOC, 32'h5555_5555, r);
      send_command(CMD_ALLOC, 32'hAAAA_AAAA, r);
      send_command(CMD_ALLOC, 32'h0000_0000, r);
   endtask

   task automatic test_random_traffic(input int count, input int src_pct, input int stall_pct,
                                      input logic retire);
      slot_reply_t r;
      handle_type h;
      logic cmd;
      int pick;
      int k;
      wait_idle();
      set_reissue_policy(retire);
      src_idle_pct = src_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         pick = $urandom_range(99);
         cmd = CMD_RELEASE;
         if (pick < 55 || issued_handles.size() == 0) begin
            cmd = CMD_ALLOC;
            h = $urandom();
         end else if (pick < 85) begin
            k = $urandom_range(issued_handles.size() - 1);
            h = issued_handles[k];
            issued_handles.delete(k);
         end else begin
            case ($urandom_range(3))
               0: h = $urandom();
               1: h = {gen_type'($urandom()),
                       index_type'($urandom_range(blocks_in_use * SLOTS - 1))};
               2: h = (released_log.size() != 0) ?
                      released_log[$urandom_range(released_log.size() - 1)] : $urandom();
               default: h = {gen_type'($urandom()),
                             index_type'(blocks_in_use * SLOTS + $urandom_range(SLOTS - 1))};
            endcase
         end
         send_command(cmd, h, r);
      end
   endtask

   task automatic test_exhaustion();
      slot_reply_t r;
      wait_idle();
      set_reissue_policy(1'b0);
      src_idle_pct = 74;
      rsp_stall_pct = 0;
      for (int n = 0; n < 2 * SLOT_TOTAL; n++) begin
         send_command(CMD_ALLOC, $urandom(), r);
         if (r.status == STATUS_EXHAUSTED) break;
      end
      send_command(CMD_ALLOC, $urandom(), r);
      if (issued_handles.size() != 0) send_command(CMD_RELEASE, issued_handles.pop_back(), r);
      send_command(CMD_ALLOC, $urandom(), r);
      send_command(CMD_ALLOC, $urandom(), r);
   endtask

   // spin one slot through release and reallocation until its generation wraps
   task automatic test_generation_wrap(input logic retire, input logic in_block0);
      slot_reply_t r;
      handle_type h;
      int found;
      int unsigned idx;
      wait_idle();
      set_reissue_policy(retire);
      src_idle_pct = 7;
      rsp_stall_pct = 7;
      found = -1;
      foreach (issued_handles[k]) begin
         idx = issued_handles[k] & INDEX_MASK;
         if (found < 0 && idx < blocks_in_use * SLOTS && (idx < SLOTS) == in_block0 &&
             issued_handles[k][31:24] == slot_gen[idx])
            found = k;
      end
      if (found < 0) return;
      h = issued_handles[found];
      issued_handles.delete(found);
      repeat (257) begin
         send_command(CMD_RELEASE, h, r);
         if (r.status == STATUS_RETIRED) break;
         send_command(CMD_ALLOC, $urandom(), r);
         if (r.status != STATUS_OK) break;
         h = issued_handles.pop_back();
      end
      send_command(CMD_ALLOC, $urandom(), r);
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.command <= CMD_ALLOC;
      req_if.handle_in <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      for (int i = 0; i < SLOT_TOTAL; i++) begin
         slot_link[i] = '0;
         slot_gen[i] = '0;
      end
      for (int i = 0; i < SLOTS; i++) slot_link[i] = LINK_MARK | ((i + 1) & INDEX_MASK);
      slot_link[SLOTS - 1] = '0;
      slot_gen[0] = 1;
      free_head = LINK_MARK;
      deferred_head = '0;
      blocks_in_use = 1;
      retire_wrapped = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_random_traffic(190, 0, 0, 1'b0);
      test_random_traffic(190, 74, 0, 1'b1);
      test_random_traffic(190, 0, 74, 1'b0);
      test_random_traffic(190, 7, 7, 1'b1);
      test_exhaustion();
      test_generation_wrap(1'b0, 1'b1);
      test_generation_wrap(1'b0, 1'b0);
      test_generation_wrap(1'b1, 1'b0);
      test_generation_wrap(1'b1, 1'b1);

      wait_idle();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: generational_handle_allocator.f
hdl/gha_pkg.sv
hdl/gha_req_bus.sv
hdl/gha_rsp_bus.sv
hdl/gha_csr.sv
hdl/gha_ctrl.sv
hdl/generational_handle_allocator.sv
test/tb.sv
